FILE: src/lhrs_pkg.sv
// Shared types and codes of the line history ring store.
package lhrs_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_FIND   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] position;
  } in_t;

  typedef struct packed {
    logic [7:0] start_pos;
    logic [7:0] byte_out;
    logic       at_write_point;
    logic       beyond_used;
    logic       overflow_error;
    logic       not_found;
  } out_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_APPEND,
    RES_READ,
    RES_FIND_OK,
    RES_FIND_NONE
  } res_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic     latch_in;
    logic     reduce;
    logic     commit;
    logic     rd_pos;
    logic     find_init;
    logic     scan_issue;
    logic     scan_miss;
    logic     load_out;
    res_sel_e res_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] req;
    logic       pos_big;
    logic       rd_hit;
    logic       scan_last;
  } status_t;

endpackage

FILE: src/lhrs_ctrl.sv
// Sequencer for the line history ring store: handshakes and operation steps.
module lhrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lhrs_pkg::status_t sts_i,
  output lhrs_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORK,
    ST_READ_WAIT,
    ST_SCAN,
    ST_FIND_WAIT,
    ST_NF_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   pend_q, pend_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    cmd_o.res_sel = lhrs_pkg::RES_NONE;
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = ST_WORK;
        end
      end
      ST_WORK: begin
        if (sts_i.pos_big &&
            (sts_i.req == lhrs_pkg::REQ_FIND || sts_i.req == lhrs_pkg::REQ_READ)) begin
          cmd_o.reduce = 1'b1;
        end else begin
          case (sts_i.req)
            lhrs_pkg::REQ_APPEND: begin
              if (out_free) begin
                cmd_o.commit   = 1'b1;
                cmd_o.load_out = 1'b1;
                cmd_o.res_sel  = lhrs_pkg::RES_APPEND;
                state_d = ST_IDLE;
              end
            end
            lhrs_pkg::REQ_READ: begin
              cmd_o.rd_pos = 1'b1;
              state_d = ST_READ_WAIT;
            end
            lhrs_pkg::REQ_FIND: begin
              cmd_o.find_init = 1'b1;
              pend_d  = 1'b0;
              state_d = ST_SCAN;
            end
            default: begin
              if (out_free) begin
                cmd_o.load_out = 1'b1;
                cmd_o.res_sel  = lhrs_pkg::RES_NONE;
                state_d = ST_IDLE;
              end
            end
          endcase
        end
      end
      ST_READ_WAIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = lhrs_pkg::RES_READ;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (pend_q && sts_i.rd_hit) begin
          // Hold the read data that matched
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.res_sel  = lhrs_pkg::RES_FIND_OK;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_FIND_WAIT;
          end
        end else if (pend_q && sts_i.scan_last) begin
          if (out_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.res_sel  = lhrs_pkg::RES_FIND_NONE;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_NF_WAIT;
          end
        end else begin
          cmd_o.scan_issue = 1'b1;
          cmd_o.scan_miss  = pend_q;
          pend_d = 1'b1;
        end
      end
      ST_FIND_WAIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = lhrs_pkg::RES_FIND_OK;
          state_d = ST_IDLE;
        end
      end
      ST_NF_WAIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.res_sel  = lhrs_pkg::RES_FIND_NONE;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free)
    else $error("result loaded while output still stalled");

  // One item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken right after a transfer");

  // A scan step only checks data from a read it issued
  a_scan_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_miss |-> $past(cmd_o.scan_issue))
    else $error("scan checked without a pending read");

endmodule

FILE: src/lhrs_dpath.sv
// Datapath of the line history ring store: byte memory, pointers, scan and result register.
module lhrs_dpath #(
  parameter int STORE_SIZE = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lhrs_pkg::in_t     in_data_i,
  input  lhrs_pkg::cmd_t    cmd_i,
  output lhrs_pkg::status_t sts_o,
  output lhrs_pkg::out_t    out_data_o
);

  localparam int AW = $clog2(STORE_SIZE);
  localparam int CW = $clog2(STORE_SIZE + 1);
  localparam int PW = (AW > 8) ? AW : 8;
  localparam logic [AW-1:0] LAST_A = AW'(STORE_SIZE - 1);
  localparam logic [CW-1:0] SIZE_C = CW'(STORE_SIZE);
  localparam logic [PW:0]   SIZE_P = (PW + 1)'(STORE_SIZE);
  localparam logic [CW:0]   SIZE_L = (CW + 1)'(STORE_SIZE);

  function automatic logic [AW-1:0] step_back(input logic [AW-1:0] p);
    return (p == '0) ? LAST_A : p - AW'(1);
  endfunction

  logic [7:0]    mem [STORE_SIZE];

  logic [1:0]    req_q;
  logic [7:0]    data_q;
  logic [PW-1:0] pos_q;
  logic [AW-1:0] wp_q;
  logic [CW-1:0] used_q;
  logic [CW-1:0] len_q;
  logic [AW-1:0] p_q;
  logic [AW-1:0] chk_q;
  logic [AW-1:0] rd_addr_q;
  logic [7:0]    rd_data_q;
  logic          rd_wr_q;
  lhrs_pkg::out_t out_q;

  logic [AW-1:0] pos_idx;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_byte;
  logic          ovf;
  logic [AW-1:0] start_s;
  lhrs_pkg::out_t res;

  assign pos_idx = pos_q[AW-1:0];
  assign rd_en   = cmd_i.rd_pos || cmd_i.scan_issue;
  assign rd_addr = cmd_i.rd_pos ? pos_idx : p_q;
  // Entries past the fill count were never written and read as zero
  assign rd_byte = rd_wr_q ? rd_data_q : 8'd0;
  assign ovf     = (data_q != 8'd0) && (({1'b0, len_q} + (CW + 1)'(1)) >= SIZE_L);
  assign start_s = (rd_addr_q == LAST_A) ? '0 : rd_addr_q + AW'(1);

  assign sts_o.req       = req_q;
  assign sts_o.pos_big   = ({1'b0, pos_q} >= SIZE_P);
  assign sts_o.rd_hit    = (rd_byte == 8'd0);
  assign sts_o.scan_last = (chk_q == LAST_A);

  always_comb begin
    res = '0;
    case (cmd_i.res_sel)
      lhrs_pkg::RES_APPEND:    res.overflow_error = ovf;
      lhrs_pkg::RES_READ:      res.byte_out = rd_byte;
      lhrs_pkg::RES_FIND_OK: begin
        res.start_pos      = 8'(start_s);
        res.at_write_point = (start_s == wp_q);
        res.beyond_used    = (CW'(start_s) > used_q);
      end
      lhrs_pkg::RES_FIND_NONE: res.not_found = 1'b1;
      default:                 res = '0;
    endcase
  end

  // Byte memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !ovf) begin
      mem[wp_q] <= data_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      rd_wr_q   <= (CW'(rd_addr) < used_q);
    end
  end

  // Item and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q  <= in_data_i.req_type;
      data_q <= in_data_i.data_byte;
      pos_q  <= PW'(in_data_i.position);
    end else if (cmd_i.reduce) begin
      pos_q  <= pos_q - PW'(STORE_SIZE);
    end
    if (cmd_i.find_init) begin
      p_q   <= step_back(step_back(pos_idx));
      chk_q <= '0;
    end else begin
      if (cmd_i.scan_issue) begin
        p_q <= step_back(p_q);
      end
      if (cmd_i.scan_miss) begin
        chk_q <= chk_q + AW'(1);
      end
    end
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  // Ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      used_q <= '0;
      len_q  <= '0;
    end else if (cmd_i.commit) begin
      if (data_q == 8'd0) begin
        len_q <= '0;
      end else if (!ovf) begin
        len_q <= len_q + CW'(1);
      end
      if (!ovf) begin
        wp_q   <= (wp_q == LAST_A) ? '0 : wp_q + AW'(1);
        used_q <= (used_q == SIZE_C) ? used_q : used_q + CW'(1);
      end
    end
  end

  assign out_data_o = out_q;

  a_used_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SIZE_C)
    else $error("used count past store size");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q < SIZE_C)
    else $error("line length reached store size");

endmodule

FILE: src/line_history_ring_store_core.sv
// Top level of the line history ring store.
//
// A circular byte store of STORE_SIZE bytes for zero-terminated text lines,
// such as a command history. Each request transfer yields exactly one result
// transfer. Append writes data_byte at the write pointer (a non-zero byte that
// would bring the current line to STORE_SIZE bytes is dropped and flagged with
// overflow_error); read returns the byte at position; find skips the terminator
// before position, walks backward for the previous zero and reports the start
// of the line after it, or not_found after one full pass. Position is taken
// modulo STORE_SIZE. An append is committed as its result is loaded; a read
// issues its memory read, then loads the byte; a find sets up its scan, then
// tests one byte per cycle through the single read port of the byte memory.
// With STORE_SIZE below 256, a read or find whose position is out of range
// first has STORE_SIZE subtracted from it until it is in range. The memory
// has no clearing pass: entries beyond the fill count read as zero, so the
// block is ready right after reset. Results wait in an output register; a
// stalled result holds the block at its last step only.
module line_history_ring_store_core #(
  parameter int STORE_SIZE = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lhrs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lhrs_pkg::out_t out_data_o
);

  lhrs_pkg::cmd_t    cmd;
  lhrs_pkg::status_t sts;

  // Sequence requests, handshakes and the result register valid
  lhrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the store, pointers, scan address and result payload
  lhrs_dpath #(
    .STORE_SIZE (STORE_SIZE)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
